[hw/rtl/aela_pkg.sv]
// Shared types, codes, the microcode program and the acceleration factor table
// for the encoder level adjuster. No dependencies; every other file imports it.
package aela_pkg;

    // Item and word widths.
    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned FACTOR_W = 12;
    localparam int unsigned STEP_W   = 32;
    localparam int unsigned CFG_AW   = 3;

    // Acceleration window: moves closer than FAST_SPAN ms apart speed up.
    localparam int unsigned ACCEL_TABLE_DEPTH = 256;
    localparam int unsigned FAST_SPAN         = 150;
    localparam logic [FACTOR_W-1:0] UNITY_Q48 = 12'd256;

    // Operation codes carried in tuser.
    localparam logic [1:0] OP_POLL   = 2'd0;
    localparam logic [1:0] OP_LOCK   = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_BASE_STEP = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_STEP  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_BRIGHT_MIN = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_BRIGHT_MAX = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_CCT_MIN   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_CCT_MAX   = 3'd5;

    // Mode codes.
    localparam logic MODE_CCT    = 1'b0;
    localparam logic MODE_BRIGHT = 1'b1;

    // Program counter and step addresses.
    localparam int unsigned PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t PC_FETCH  = 3'd0;
    localparam pc_t PC_DECODE = 3'd1;
    localparam pc_t PC_FACTOR = 3'd2;
    localparam pc_t PC_SCALE  = 3'd3;
    localparam pc_t PC_MUL    = 3'd4;
    localparam pc_t PC_APPLY  = 3'd5;

    // Datapath micro-operations.
    typedef enum logic [2:0] {
        UOP_NOP    = 3'd0,
        UOP_LOAD   = 3'd1,
        UOP_DECODE = 3'd2,
        UOP_FACTOR = 3'd3,
        UOP_SCALE  = 3'd4,
        UOP_MUL    = 3'd5,
        UOP_APPLY  = 3'd6
    } uop_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_NO_INPUT = 3'd2,
        COND_NO_MOVE  = 3'd3,
        COND_OUT_BUSY = 3'd4
    } cond_t;

    // One control word: operation, jump condition and target, return flag,
    // and whether the input channel is open in this step.
    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        pc_t   target;
        logic  ret;
        logic  take;
    } uword_t;

    // Status from the datapath that the jump conditions test.
    typedef struct packed {
        logic in_valid;
        logic no_move;
        logic out_free;
    } status_t;

    // The program. A taken jump goes to target; otherwise a step with ret set
    // returns to fetch and any other step falls through to the next one.
    function automatic uword_t ucode_rom(pc_t pc);
        uword_t w;
        case (pc)
            PC_FETCH:  w = '{uop: UOP_LOAD,   cond: COND_NO_INPUT, target: PC_FETCH,
                             ret: 1'b0, take: 1'b1};
            PC_DECODE: w = '{uop: UOP_DECODE, cond: COND_NO_MOVE,  target: PC_FETCH,
                             ret: 1'b0, take: 1'b0};
            PC_FACTOR: w = '{uop: UOP_FACTOR, cond: COND_NEVER,    target: PC_FETCH,
                             ret: 1'b0, take: 1'b0};
            PC_SCALE:  w = '{uop: UOP_SCALE,  cond: COND_NEVER,    target: PC_FETCH,
                             ret: 1'b0, take: 1'b0};
            PC_MUL:    w = '{uop: UOP_MUL,    cond: COND_NEVER,    target: PC_FETCH,
                             ret: 1'b0, take: 1'b0};
            PC_APPLY:  w = '{uop: UOP_APPLY,  cond: COND_OUT_BUSY, target: PC_APPLY,
                             ret: 1'b1, take: 1'b0};
            default:   w = '{uop: UOP_NOP,    cond: COND_ALWAYS,   target: PC_FETCH,
                             ret: 1'b1, take: 1'b0};
        endcase
        return w;
    endfunction

    // Q4.8 factor round(256 * exp(k / 70)) for k = 0..149.
    localparam logic [FACTOR_W-1:0] ACCEL_Q48 [0:FAST_SPAN-1] = '{
         256,  260,  263,  267,  271,  275,  279,  283,  287,  291,
         295,  300,  304,  308,  313,  317,  322,  326,  331,  336,
         341,  346,  351,  356,  361,  366,  371,  376,  382,  387,
         393,  399,  404,  410,  416,  422,  428,  434,  441,  447,
         453,  460,  466,  473,  480,  487,  494,  501,  508,  516,
         523,  530,  538,  546,  554,  562,  570,  578,  586,  595,
         603,  612,  621,  630,  639,  648,  657,  667,  676,  686,
         696,  706,  716,  726,  737,  747,  758,  769,  780,  791,
         803,  814,  826,  838,  850,  862,  875,  887,  900,  913,
         926,  939,  953,  967,  980,  995, 1009, 1023, 1038, 1053,
        1068, 1084, 1099, 1115, 1131, 1147, 1164, 1181, 1198, 1215,
        1232, 1250, 1268, 1286, 1305, 1323, 1343, 1362, 1381, 1401,
        1421, 1442, 1463, 1484, 1505, 1527, 1549, 1571, 1594, 1617,
        1640, 1663, 1687, 1712, 1736, 1761, 1787, 1812, 1838, 1865,
        1892, 1919, 1946, 1974, 2003, 2032, 2061, 2091, 2121, 2151
    };

    // Factor for the time since the last move; unity when idle too long or
    // when two moves share one tick.
    function automatic logic [FACTOR_W-1:0] accel_factor(logic [TICK_W-1:0] dt);
        logic [7:0] idx;
        logic [FACTOR_W-1:0] f;
        idx = 8'(8'(FAST_SPAN) - dt[7:0]);
        if ((dt == '0) || (dt >= TICK_W'(FAST_SPAN)) || (dt >= TICK_W'(ACCEL_TABLE_DEPTH))) begin
            f = UNITY_Q48;
        end else begin
            f = ACCEL_Q48[idx];
        end
        return f;
    endfunction

endpackage

[hw/rtl/aela_sequencer.sv]
// Microcode sequencer: program counter, control store and jump logic.
// Depends on aela_pkg for the program, control word and status types.
module aela_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  aela_pkg::status_t sts,
    output aela_pkg::uword_t  ctrl
);
    import aela_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t word;
    logic   jump;

    // Fetch the control word of the current step.
    assign word = ucode_rom(pc_reg);
    assign ctrl = word;

    // Evaluate the jump condition.
    always_comb begin
        case (word.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !sts.in_valid;
            COND_NO_MOVE:  jump = sts.no_move;
            COND_OUT_BUSY: jump = !sts.out_free;
            default:       jump = 1'b1;
        endcase
    end

    // Next step: jump target, return to fetch, or fall through.
    always_comb begin
        if (jump) begin
            pc_next = word.target;
        end else if (word.ret) begin
            pc_next = PC_FETCH;
        end else begin
            pc_next = pc_reg + pc_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

`ifndef ASSERT_OFF
    // Reset puts the sequencer back at fetch.
    a_reset_fetch: assert property (@(posedge aclk) !aresetn |=> pc_reg == PC_FETCH)
        else $error("sequencer not at fetch after reset");
    // The program never runs past its last step.
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= PC_APPLY)
        else $error("program counter outside the program");
    // A stalled result holds the sequencer in the apply step.
    a_apply_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == PC_APPLY && !sts.out_free) |=> pc_reg == PC_APPLY)
        else $error("apply step left while the output word was busy");
`endif

endmodule

[hw/rtl/aela_datapath.sv]
// Datapath of the level adjuster: item capture, configuration registers,
// encoder state, step scaling, level update and the output word register.
// Depends on aela_pkg for codes, micro-operations and the factor table.
module aela_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  aela_pkg::uword_t             ctrl,
    output aela_pkg::status_t            sts,
    input  logic                         s_tvalid,
    input  logic [55:0]                  s_tdata,
    input  logic [1:0]                   s_tuser,
    input  logic                         cfg_wr_en,
    input  logic [aela_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [15:0]                  cfg_wr_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [63:0]                  m_tdata,
    output logic [0:0]                   m_tuser
);
    import aela_pkg::*;

    // Captured item.
    logic [1:0]         op_reg;
    logic [LEVEL_W-1:0] cnt_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic               mvalid_reg;
    logic               nmode_reg;

    // Configuration registers.
    logic [LEVEL_W-1:0] base_step_reg, max_step_reg;
    logic [LEVEL_W-1:0] bright_min_reg, bright_max_reg, cct_min_reg, cct_max_reg;

    // Encoder and level state.
    logic [LEVEL_W-1:0] last_count_reg;
    logic [TICK_W-1:0]  last_move_tick_reg;
    logic [LEVEL_W-1:0] bright_acc_reg, cct_acc_reg;
    logic               mode_reg, locked_reg;

    // Intermediate results between steps.
    logic signed [LEVEL_W-1:0] delta_reg;
    logic [FACTOR_W-1:0]       factor_reg;
    logic [LEVEL_W-1:0]        step_reg;
    logic signed [STEP_W-1:0]  change_reg;

    // Output word.
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_bright_reg, out_cct_reg;
    logic [STEP_W-1:0]  out_step_reg;
    logic               out_mode_reg;

    logic [LEVEL_W-1:0] diff;
    logic               poll_ok;
    logic [TICK_W-1:0]  dt;
    logic [27:0]        scaled_full;
    logic [19:0]        scaled;
    logic [LEVEL_W-1:0] step_next;
    logic signed [32:0] product;
    logic               out_free;
    logic               load_out;
    logic [LEVEL_W-1:0] level_sel, lo_sel, hi_sel, level_next;
    logic signed [33:0] level_sum;

    // Count change and whether this item is a poll taken while unlocked.
    assign diff     = cnt_reg - last_count_reg;
    assign poll_ok  = (op_reg == OP_POLL) && !locked_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (ctrl.uop == UOP_APPLY) && out_free;

    assign sts.in_valid = s_tvalid;
    assign sts.no_move  = !poll_ok || (diff == '0);
    assign sts.out_free = out_free;

    // Time since the last move and the scaled, limited step.
    assign dt          = tick_reg - last_move_tick_reg;
    assign scaled_full = 28'(base_step_reg) * 28'(factor_reg) + 28'd128;
    assign scaled      = scaled_full[27:8];
    assign step_next   = (scaled > 20'(max_step_reg)) ? max_step_reg : scaled[15:0];
    assign product     = 33'(delta_reg) * $signed({17'd0, step_reg});

    // Level update with max clamp first, then min clamp.
    always_comb begin
        if (mode_reg == MODE_BRIGHT) begin
            level_sel = bright_acc_reg;
            lo_sel    = bright_min_reg;
            hi_sel    = bright_max_reg;
        end else begin
            level_sel = cct_acc_reg;
            lo_sel    = cct_min_reg;
            hi_sel    = cct_max_reg;
        end
        level_sum = $signed({18'd0, level_sel}) + 34'(change_reg);
        if (level_sum > $signed({18'd0, hi_sel})) begin
            level_sum = $signed({18'd0, hi_sel});
        end
        if (level_sum < $signed({18'd0, lo_sel})) begin
            level_sum = $signed({18'd0, lo_sel});
        end
        level_next = level_sum[LEVEL_W-1:0];
    end

    // Item capture and intermediate results.
    always_ff @(posedge aclk) begin
        if ((ctrl.uop == UOP_LOAD) && s_tvalid) begin
            op_reg     <= s_tuser;
            cnt_reg    <= s_tdata[15:0];
            tick_reg   <= s_tdata[47:16];
            mvalid_reg <= s_tdata[48];
            nmode_reg  <= s_tdata[49];
        end
        if (ctrl.uop == UOP_DECODE) begin
            delta_reg <= $signed(diff);
        end
        if (ctrl.uop == UOP_FACTOR) begin
            factor_reg <= accel_factor(dt);
        end
        if (ctrl.uop == UOP_SCALE) begin
            step_reg <= step_next;
        end
        if (ctrl.uop == UOP_MUL) begin
            change_reg <= product[STEP_W-1:0];
        end
        if (load_out) begin
            out_step_reg <= change_reg;
            out_mode_reg <= mode_reg;
            if (mode_reg == MODE_BRIGHT) begin
                out_bright_reg <= level_next;
                out_cct_reg    <= cct_acc_reg;
            end else begin
                out_bright_reg <= bright_acc_reg;
                out_cct_reg    <= level_next;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_step_reg  <= 16'd328;
            max_step_reg   <= 16'd3277;
            bright_min_reg <= 16'd0;
            bright_max_reg <= 16'hFFFF;
            cct_min_reg    <= 16'd0;
            cct_max_reg    <= 16'hFFFF;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BASE_STEP:  base_step_reg  <= cfg_wr_data;
                CFG_MAX_STEP:   max_step_reg   <= cfg_wr_data;
                CFG_BRIGHT_MIN: bright_min_reg <= cfg_wr_data;
                CFG_BRIGHT_MAX: bright_max_reg <= cfg_wr_data;
                CFG_CCT_MIN:    cct_min_reg    <= cfg_wr_data;
                CFG_CCT_MAX:    cct_max_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Encoder state: lock, resync, mode, last count, move time and levels.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg     <= '0;
            last_move_tick_reg <= '0;
            bright_acc_reg     <= '0;
            cct_acc_reg        <= 16'h8000;
            mode_reg           <= MODE_CCT;
            locked_reg         <= 1'b0;
        end else begin
            if (ctrl.uop == UOP_DECODE) begin
                case (op_reg)
                    OP_LOCK: begin
                        locked_reg <= 1'b1;
                    end
                    OP_UNLOCK: begin
                        locked_reg     <= 1'b0;
                        last_count_reg <= cnt_reg;
                    end
                    OP_POLL: begin
                        if (!locked_reg) begin
                            last_count_reg <= cnt_reg;
                            if (mvalid_reg) begin
                                mode_reg <= nmode_reg;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (ctrl.uop == UOP_FACTOR) begin
                last_move_tick_reg <= tick_reg;
            end
            if (load_out) begin
                if (mode_reg == MODE_BRIGHT) begin
                    bright_acc_reg <= level_next;
                end else begin
                    cct_acc_reg <= level_next;
                end
            end
        end
    end

    // Output word valid: set on load, cleared when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_step_reg, out_cct_reg, out_bright_reg};
    assign m_tuser  = out_mode_reg;

`ifndef ASSERT_OFF
    // Reset leaves the color temperature at half scale and nothing pending.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (cct_acc_reg == 16'h8000) && !out_valid_reg && !locked_reg)
        else $error("state not at reset values");
    // A lock never takes effect while a level update is in flight.
    a_no_apply_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.uop == UOP_APPLY) |-> !locked_reg)
        else $error("level update while locked");
    // A loaded output word carries the level just written into the state.
    a_out_matches_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (out_bright_reg == bright_acc_reg) && (out_cct_reg == cct_acc_reg))
        else $error("output word differs from the stored levels");
`endif

endmodule

[hw/rtl/accelerated_encoder_level_adjust.sv]
// Accelerated rotary-encoder level adjuster: the microcode sequencer and the datapath
// it drives. Depends on aela_pkg, aela_sequencer and aela_datapath.
//
// Usage:
//   The input channel takes one word per poll: tuser carries the operation
//   (poll, lock, or unlock, which also resyncs) and tdata the count, tick and mode.
//   The output channel gives one word for each poll that moves the count while
//   unlocked: both levels after the update, the applied step and the mode.
//   Registers are written through cfg_wr_en/cfg_addr/cfg_wr_data while idle.
// Sequencing:
//   A moving poll is accepted in the fetch step and runs through the decode,
//   factor, scale, multiply and apply steps; the next word is accepted back
//   in fetch. Lock, unlock, locked polls and polls without movement return
//   to fetch after decode. The six-step microcode program runs over one
//   shared datapath, so no word is taken before the last one is finished.
// Reset:
//   aresetn is synchronous, active low. It restores the register defaults,
//   sets brightness to 0 and color temperature to half scale, and unlocks.
// Stall:
//   A finished word waits in the output register while the next input word is
//   taken and decoded; a second output word waits in the apply step until the
//   first one is taken, and no word is dropped.
module accelerated_encoder_level_adjust (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input channel.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // tdata: counter value[15:0], tick[47:16], mode valid[48], requested mode[49], zeros
    input  logic [55:0]                  s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]                   s_tuser,
    // Output channel.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // tdata: brightness level[15:0], color temperature level[31:16], applied step[63:32]
    output logic [63:0]                  m_tdata,
    // tuser: active mode[0]
    output logic [0:0]                   m_tuser,
    // Configuration write port.
    input  logic                         cfg_wr_en,
    input  logic [aela_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [15:0]                  cfg_wr_data
);
    import aela_pkg::*;

    uword_t  ctrl;
    status_t sts;

    // The input channel is open only in the fetch step.
    assign s_tready = ctrl.take;

    aela_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .ctrl    (ctrl)
    );

    aela_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .sts         (sts),
        .s_tvalid    (s_tvalid),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

[verif/accelerated_encoder_level_adjust_tb.sv]
// Self-checking testbench for accelerated_encoder_level_adjust: it drives polls, locks and
// unlocks, predicts every level update in its own encoder model, and checks each output word.
// Depends on aela_pkg and the accelerated_encoder_level_adjust RTL.
module accelerated_encoder_level_adjust_tb;
    import aela_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0]        OP_RESERVED  = 2'd3;
    localparam logic [CFG_AW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_SPARE_HI = 3'd7;

    // Acceleration window and step limits of the encoder model.
    localparam int unsigned FAST_WINDOW_MS = 150;
    localparam int unsigned TABLE_SPAN     = 256;
    localparam logic [11:0] UNITY_FACTOR   = 12'd256;
    localparam longint      STEP_HI        = 64'sd2147483647;
    localparam longint      STEP_LO        = -64'sd2147483648;

    // Speed-up factor round(256 * exp(k / 70)) in Q4.8, k = 0..149.
    localparam logic [11:0] SPEEDUP_Q48 [0:149] = '{
         256,  260,  263,  267,  271,  275,  279,  283,  287,  291,
         295,  300,  304,  308,  313,  317,  322,  326,  331,  336,
         341,  346,  351,  356,  361,  366,  371,  376,  382,  387,
         393,  399,  404,  410,  416,  422,  428,  434,  441,  447,
         453,  460,  466,  473,  480,  487,  494,  501,  508,  516,
         523,  530,  538,  546,  554,  562,  570,  578,  586,  595,
         603,  612,  621,  630,  639,  648,  657,  667,  676,  686,
         696,  706,  716,  726,  737,  747,  758,  769,  780,  791,
         803,  814,  826,  838,  850,  862,  875,  887,  900,  913,
         926,  939,  953,  967,  980,  995, 1009, 1023, 1038, 1053,
        1068, 1084, 1099, 1115, 1131, 1147, 1164, 1181, 1198, 1215,
        1232, 1250, 1268, 1286, 1305, 1323, 1343, 1362, 1381, 1401,
        1421, 1442, 1463, 1484, 1505, 1527, 1549, 1571, 1594, 1617,
        1640, 1663, 1687, 1712, 1736, 1761, 1787, 1812, 1838, 1865,
        1892, 1919, 1946, 1974, 2003, 2032, 2061, 2091, 2121, 2151
    };

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] count;
        logic [31:0] tick;
        logic        mode_valid;
        logic        req_mode;
    } poll_word_t;

    typedef struct packed {
        logic [15:0]        bright;
        logic [15:0]        cct;
        logic signed [31:0] step;
        logic               mode;
    } level_word_t;

    // Clock, reset and block ports; the ones the bench drives are known from time zero.
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = OP_POLL;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = CFG_BASE_STEP;
    logic [15:0] cfg_wr_data = '0;

    // Register copy of the encoder model.
    logic [15:0] base_step_q  = 16'd328;
    logic [15:0] max_step_q   = 16'd3277;
    logic [15:0] bright_min_q = 16'd0;
    logic [15:0] bright_max_q = 16'd65535;
    logic [15:0] cct_min_q    = 16'd0;
    logic [15:0] cct_max_q    = 16'd65535;

    // State of the encoder model after reset.
    logic [15:0] seen_count   = 16'd0;
    logic [31:0] move_tick    = 32'd0;
    logic [15:0] bright_level = 16'd0;
    logic [15:0] temp_level   = 16'd32768;
    logic        cur_mode     = MODE_CCT;
    logic        is_locked    = 1'b0;

    poll_word_t  pending_polls [$];
    level_word_t expected_levels [$];

    // Stimulus-side encoder position and clock.
    logic [15:0] enc_pos = 16'd0;
    logic [31:0] now_ms  = 32'd0;

    int error_count    = 0;
    int words_queued   = 0;
    int words_accepted = 0;
    int levels_checked = 0;
    int settings_run   = 1;
    int gap_left       = 0;
    int out_wait       = 0;

    accelerated_encoder_level_adjust u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Encoder model: works out the level update, if any, that one accepted word causes.
    task automatic predict_level_update(input poll_word_t w);
        logic [15:0] diff;
        logic [31:0] dt;
        logic [7:0]  idx;
        logic [11:0] factor;
        logic [31:0] step;
        int          delta;
        longint      change;
        longint      lvl;
        level_word_t res;
        if (w.op == OP_LOCK) begin
            is_locked = 1'b1;
        end else if (w.op == OP_UNLOCK) begin
            is_locked  = 1'b0;
            seen_count = w.count;
        end else if (w.op == OP_POLL && !is_locked) begin
            if (w.mode_valid) begin
                cur_mode = w.req_mode;
            end
            diff       = w.count - seen_count;
            seen_count = w.count;
            if (diff != 16'd0) begin
                delta     = int'($signed(diff));
                dt        = w.tick - move_tick;
                move_tick = w.tick;
                // Moves that come quickly get a larger step.
                if (dt == 32'd0 || dt >= FAST_WINDOW_MS || dt >= TABLE_SPAN) begin
                    factor = UNITY_FACTOR;
                end else begin
                    idx    = 8'(FAST_WINDOW_MS - dt);
                    factor = SPEEDUP_Q48[idx];
                end
                step = (32'(base_step_q) * 32'(factor) + 32'd128) >> 8;
                if (step > 32'(max_step_q)) begin
                    step = 32'(max_step_q);
                end
                change = longint'(delta) * longint'(step);
                if (change > STEP_HI) change = STEP_HI;
                if (change < STEP_LO) change = STEP_LO;
                // The max clamp comes first, so a min above max wins.
                if (cur_mode == MODE_BRIGHT) begin
                    lvl = longint'(bright_level) + change;
                    if (lvl > longint'(bright_max_q)) lvl = longint'(bright_max_q);
                    if (lvl < longint'(bright_min_q)) lvl = longint'(bright_min_q);
                    bright_level = 16'(lvl);
                end else begin
                    lvl = longint'(temp_level) + change;
                    if (lvl > longint'(cct_max_q)) lvl = longint'(cct_max_q);
                    if (lvl < longint'(cct_min_q)) lvl = longint'(cct_min_q);
                    temp_level = 16'(lvl);
                end
                res.bright = bright_level;
                res.cct    = temp_level;
                res.step   = 32'(change);
                res.mode   = cur_mode;
                expected_levels.push_back(res);
            end
        end
    endtask

    // Queue a run of words: mostly polls with small turns, some locks, unlocks and
    // reserved operations, large jumps in the count and ticks that span the window.
    task automatic queue_polls(input int count_items, input int jump_pct);
        poll_word_t  w;
        int          roll;
        logic [15:0] mv;
        logic [31:0] adv;
        for (int i = 0; i < count_items; i++) begin
            roll = int'($urandom_range(99, 0));
            if (roll < 2) begin
                w.op = OP_LOCK;
            end else if (roll < 7) begin
                w.op = OP_UNLOCK;
            end else if (roll < 9) begin
                w.op = OP_RESERVED;
            end else begin
                w.op = OP_POLL;
            end
            // Encoder movement, either way, wrapping at 16 bits.
            roll = int'($urandom_range(99, 0));
            if (roll < 20) begin
                mv = 16'd0;
            end else if (roll < 100 - jump_pct - 15) begin
                mv = 16'($urandom_range(4, 1));
            end else if (roll < 100 - jump_pct) begin
                mv = 16'($urandom_range(200, 5));
            end else begin
                mv = 16'($urandom);
            end
            if ($urandom_range(1, 0) == 1) begin
                enc_pos = enc_pos + mv;
            end else begin
                enc_pos = enc_pos - mv;
            end
            // Time since the previous word, now and then with a wrap of the tick.
            roll = int'($urandom_range(99, 0));
            if (roll < 10) begin
                adv = 32'd0;
            end else if (roll < 50) begin
                adv = 32'($urandom_range(149, 1));
            end else if (roll < 85) begin
                adv = 32'($urandom_range(400, 150));
            end else if (roll < 95) begin
                adv = 32'($urandom_range(5000, 400));
            end else begin
                adv = 32'($urandom);
            end
            now_ms       = now_ms + adv;
            w.count      = enc_pos;
            w.tick       = now_ms;
            w.mode_valid = ($urandom_range(3, 0) == 0);
            w.req_mode   = 1'($urandom_range(1, 0));
            pending_polls.push_back(w);
            words_queued++;
        end
    endtask

    // Write one register while the block is idle and update the model copy.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            CFG_BASE_STEP:  base_step_q  = val;
            CFG_MAX_STEP:   max_step_q   = val;
            CFG_BRIGHT_MIN: bright_min_q = val;
            CFG_BRIGHT_MAX: bright_max_q = val;
            CFG_CCT_MIN:    cct_min_q    = val;
            CFG_CCT_MAX:    cct_max_q    = val;
            default: ;
        endcase
    endtask

    // Hold the sender until every queued word is taken and every result has come.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while ((pending_polls.size() != 0) || s_tvalid || m_tvalid
                   || (expected_levels.size() != 0));
        repeat (8) @(negedge aclk);
    endtask

    // Driver: presents pending words, with a random gap before each one.
    always @(posedge aclk) begin : drive_polls
        poll_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                w.op         = s_tuser;
                w.count      = s_tdata[15:0];
                w.tick       = s_tdata[47:16];
                w.mode_valid = s_tdata[48];
                w.req_mode   = s_tdata[49];
                predict_level_update(w);
                words_accepted++;
                gap_left = int'($urandom_range(5, 0));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    s_tvalid <= 1'b0;
                    gap_left--;
                end else if (pending_polls.size() != 0) begin
                    w = pending_polls.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= w.op;
                    s_tdata  <= {6'd0, w.req_mode, w.mode_valid, w.tick, w.count};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes output words after a random wait and checks them in order.
    always @(posedge aclk) begin : watch_levels
        level_word_t got;
        level_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.bright = m_tdata[15:0];
                got.cct    = m_tdata[31:16];
                got.step   = m_tdata[63:32];
                got.mode   = m_tuser[0];
                if (expected_levels.size() == 0) begin
                    flag_mismatch($sformatf("output word %h with none expected", m_tdata));
                end else begin
                    want = expected_levels.pop_front();
                    if (got !== want) begin
                        flag_mismatch($sformatf("got %h %h %h %b, expected %h %h %h %b",
                            got.bright, got.cct, got.step, got.mode,
                            want.bright, want.cct, want.step, want.mode));
                    end
                    levels_checked++;
                end
                out_wait = int'($urandom_range(5, 0));
            end
            if (out_wait > 0) begin
                m_tready <= 1'b0;
                if (m_tvalid) begin
                    out_wait--;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus: several register settings, each with a run of words and a full drain.
    initial begin : run_test
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults with ordinary turning.
        queue_polls(400, 3);
        wait_drained();

        // Narrow level windows and a slow base step with a high limit.
        settings_run++;
        write_reg(CFG_BASE_STEP, 16'd40);
        write_reg(CFG_MAX_STEP, 16'd20000);
        write_reg(CFG_BRIGHT_MIN, 16'd1000);
        write_reg(CFG_BRIGHT_MAX, 16'd50000);
        write_reg(CFG_CCT_MIN, 16'd5000);
        write_reg(CFG_CCT_MAX, 16'd60000);
        queue_polls(400, 3);
        wait_drained();

        // Brightness minimum above its maximum, spare indexes, tick close to wrapping.
        settings_run++;
        write_reg(CFG_BRIGHT_MIN, 16'd40000);
        write_reg(CFG_BRIGHT_MAX, 16'd30000);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0001);
        now_ms = 32'hFFFF_FF00;
        queue_polls(300, 3);
        wait_drained();

        // Largest steps with frequent big jumps in the count.
        settings_run++;
        write_reg(CFG_BASE_STEP, 16'hFFFF);
        write_reg(CFG_MAX_STEP, 16'hFFFF);
        write_reg(CFG_BRIGHT_MIN, 16'd0);
        write_reg(CFG_BRIGHT_MAX, 16'hFFFF);
        write_reg(CFG_CCT_MIN, 16'd0);
        write_reg(CFG_CCT_MAX, 16'hFFFF);
        queue_polls(300, 40);
        wait_drained();

        // Random register values.
        settings_run++;
        write_reg(CFG_BASE_STEP, 16'($urandom_range(3000, 0)));
        write_reg(CFG_MAX_STEP, 16'($urandom));
        write_reg(CFG_BRIGHT_MIN, 16'($urandom_range(20000, 0)));
        write_reg(CFG_BRIGHT_MAX, 16'($urandom_range(65535, 15000)));
        write_reg(CFG_CCT_MIN, 16'($urandom_range(20000, 0)));
        write_reg(CFG_CCT_MAX, 16'($urandom_range(65535, 15000)));
        queue_polls(400, 10);
        wait_drained();

        if (expected_levels.size() != 0) begin
            flag_mismatch($sformatf("%0d output words never came", expected_levels.size()));
        end
        if (words_accepted != words_queued) begin
            flag_mismatch($sformatf("%0d words accepted of %0d queued",
                words_accepted, words_queued));
        end

        $display("accelerated_encoder_level_adjust_tb: %0d input words over %0d register sets,",
            words_accepted, settings_run);
        $display("accelerated_encoder_level_adjust_tb: %0d level updates compared, %0d errors",
            levels_checked, error_count);
        if (error_count == 0) begin
            $display("accelerated_encoder_level_adjust_tb: clean");
        end else begin
            $display("accelerated_encoder_level_adjust_tb: errors");
        end
        $finish;
    end

    // Run limit, far above what the full stimulus needs.
    initial begin : run_limit
        #5000000;
        $display("accelerated_encoder_level_adjust_tb: stopped with %0d words pending",
            pending_polls.size() + expected_levels.size());
        $display("accelerated_encoder_level_adjust_tb: errors");
        $finish;
    end
endmodule
